// ===== design/mmde_pkg.sv =====
// Shared types, sizes and helper functions for the matrix multiply dot engine.
// No dependencies; every other design file imports this package.
package mmde_pkg;

    localparam int MAX_DIM   = 16;
    localparam int ELEM_BITS = 16;

    localparam int FIELD_W   = 4;
    localparam int VALUE_W   = 16;
    localparam int SIZE_W    = 5;
    localparam int PROD_W    = 36;
    localparam int MUL_W     = 2 * ELEM_BITS;
    localparam int DATA_W    = 32;
    localparam int PADDR_W   = 4;

    localparam int EFF_MAX   = (MAX_DIM < 31) ? MAX_DIM : 31;
    localparam int EFF_W     = $clog2(EFF_MAX + 1);
    localparam int DEPTH     = MAX_DIM * MAX_DIM;
    localparam int ADDR_W    = $clog2(DEPTH);

    typedef enum logic [1:0] {
        OP_WRITE_A = 2'd0,
        OP_WRITE_B = 2'd1,
        OP_READ_C  = 2'd2
    } t_opcode;

    typedef enum logic [1:0] {
        REG_ROWS_A    = 2'd0,
        REG_INNER_DIM = 2'd1,
        REG_COLS_B    = 2'd2
    } t_reg_idx;

    typedef struct packed {
        logic [EFF_W-1:0] nr;
        logic [EFF_W-1:0] nk;
        logic [EFF_W-1:0] nc;
    } t_sizes;

    typedef struct packed {
        logic clear;
        logic load;
    } t_mac_ctl;

    function automatic logic [EFF_W-1:0] eff_size(input logic [SIZE_W-1:0] raw);
        logic [EFF_W-1:0] res;
        if (raw > SIZE_W'(EFF_MAX)) begin
            res = EFF_W'(EFF_MAX);
        end else begin
            res = EFF_W'(raw);
        end
        return res;
    endfunction

    function automatic logic [ADDR_W-1:0] elem_addr(input logic [EFF_W-1:0] r,
                                                     input logic [EFF_W-1:0] c);
        logic [ADDR_W-1:0] res;
        res = ADDR_W'(ADDR_W'(r) * ADDR_W'(MAX_DIM)) + ADDR_W'(c);
        return res;
    endfunction

endpackage

// ===== design/mmde_cfg_regs.sv =====
// Size registers behind the APB-style configuration port.
// Depends on mmde_pkg for register codes and the effective size function.
module mmde_cfg_regs
    import mmde_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0]  pwdata,
    output logic [DATA_W-1:0]  prdata,
    output logic               pready,
    output t_sizes             o_sizes
);

    logic [SIZE_W-1:0] r_rows_a;
    logic [SIZE_W-1:0] r_inner_dim;
    logic [SIZE_W-1:0] r_cols_b;
    logic              wr_en;
    t_reg_idx          reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = t_reg_idx'(paddr[PADDR_W-1:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_a    <= SIZE_W'(16);
            r_inner_dim <= SIZE_W'(16);
            r_cols_b    <= SIZE_W'(16);
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_ROWS_A:    r_rows_a    <= pwdata[SIZE_W-1:0];
                REG_INNER_DIM: r_inner_dim <= pwdata[SIZE_W-1:0];
                REG_COLS_B:    r_cols_b    <= pwdata[SIZE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_ROWS_A:    prdata = DATA_W'(r_rows_a);
            REG_INNER_DIM: prdata = DATA_W'(r_inner_dim);
            REG_COLS_B:    prdata = DATA_W'(r_cols_b);
            default:       prdata = '0;
        endcase
    end

    assign o_sizes.nr = eff_size(r_rows_a);
    assign o_sizes.nk = eff_size(r_inner_dim);
    assign o_sizes.nc = eff_size(r_cols_b);

endmodule

// ===== design/mmde_store.sv =====
// Element store for one matrix: one write port and one registered read port.
// Depends on mmde_pkg for the element width and store depth.
module mmde_store
    import mmde_pkg::*;
(
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [ADDR_W-1:0]           i_waddr,
    input  logic signed [ELEM_BITS-1:0] i_wdata,
    input  logic [ADDR_W-1:0]           i_raddr,
    output logic signed [ELEM_BITS-1:0] o_rdata
);

    logic signed [ELEM_BITS-1:0] r_mem [DEPTH];
    logic signed [ELEM_BITS-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/mmde_mac.sv =====
// Shared multiply-accumulate unit: a registered multiplier feeding a wrapping accumulator.
// Depends on mmde_pkg for widths and the control struct.
module mmde_mac
    import mmde_pkg::*;
(
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  t_mac_ctl                    i_ctl,
    input  logic signed [ELEM_BITS-1:0] i_a,
    input  logic signed [ELEM_BITS-1:0] i_b,
    output logic                        o_busy,
    output logic [PROD_W-1:0]           o_acc
);

    logic signed [MUL_W-1:0]  r_mul;
    logic                     r_mul_vld;
    logic signed [PROD_W-1:0] r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mul_vld <= 1'b0;
        end else if (i_ctl.clear) begin
            r_mul_vld <= 1'b0;
        end else begin
            r_mul_vld <= i_ctl.load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_mul <= i_a * i_b;
        end
        if (i_ctl.clear) begin
            r_acc <= '0;
        end else if (r_mul_vld) begin
            r_acc <= r_acc + PROD_W'(r_mul);
        end
    end

    assign o_busy = r_mul_vld;
    assign o_acc  = r_acc;

endmodule

// ===== design/matrix_multiply_dot_engine_unit.sv =====
// Top level of the matrix multiply dot engine: command sequencer and result register.
// Depends on mmde_pkg, mmde_cfg_regs, mmde_store and mmde_mac.
//
// A command word is taken when start is high and busy is low. Opcodes write one
// element of A or B, or request one element of C = A * B. Writes complete in the
// accepting cycle, give no result and leave busy low. A request walks inner_dim
// element pairs through one shared multiplier and accumulator, one pair per cycle;
// busy stays high while the pairs pass the store read, multiplier and accumulator
// registers, and the result word appears on o_product and o_error with o_valid
// high for one cycle as busy falls.
// A request outside the configured sizes answers the next cycle with o_error set
// and a zero product. The receiver cannot stall; each result word is shown once.
// Reset sets all three sizes to 16 and leaves the element stores unwritten; every
// element must be loaded before it takes part in a request. The user must write
// sizes over the APB port only while the block is idle, which it does not enforce.
module matrix_multiply_dot_engine_unit
    import mmde_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [PADDR_W-1:0]        paddr,
    input  logic [DATA_W-1:0]         pwdata,
    output logic [DATA_W-1:0]         prdata,
    output logic                      pready,
    input  logic                      start,
    output logic                      busy,
    input  logic [1:0]                i_opcode,
    input  logic [FIELD_W-1:0]        i_row,
    input  logic [FIELD_W-1:0]        i_col,
    input  logic signed [VALUE_W-1:0] i_value,
    output logic                      o_valid,
    output logic signed [PROD_W-1:0]  o_product,
    output logic                      o_error
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_DRAIN
    } t_state;

    t_state                      r_state;
    logic [EFF_W-1:0]            r_k;
    logic [EFF_W-1:0]            r_row;
    logic [EFF_W-1:0]            r_col;
    logic                        r_rd_vld;
    logic                        r_valid;
    logic [PROD_W-1:0]           r_product;
    logic                        r_error;

    t_sizes                      sizes;
    t_mac_ctl                    mac_ctl;
    t_opcode                     op;
    logic                        accept;
    logic                        in_rows;
    logic                        in_inner_col;
    logic                        in_inner_row;
    logic                        in_cols;
    logic                        a_we;
    logic                        b_we;
    logic                        req_ok;
    logic                        req_err;
    logic                        last_k;
    logic                        mac_busy;
    logic [PROD_W-1:0]           acc;
    logic [ADDR_W-1:0]           waddr;
    logic [ADDR_W-1:0]           a_raddr;
    logic [ADDR_W-1:0]           b_raddr;
    logic signed [ELEM_BITS-1:0] wdata;
    logic signed [ELEM_BITS-1:0] a_rdata;
    logic signed [ELEM_BITS-1:0] b_rdata;

    mmde_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_sizes (sizes)
    );

    assign accept       = start && !busy;
    assign op           = t_opcode'(i_opcode);
    assign in_rows      = i_row < sizes.nr;
    assign in_inner_col = i_col < sizes.nk;
    assign in_inner_row = i_row < sizes.nk;
    assign in_cols      = i_col < sizes.nc;
    assign waddr        = elem_addr(EFF_W'(i_row), EFF_W'(i_col));
    assign wdata        = ELEM_BITS'(i_value);

    always_comb begin
        a_we    = 1'b0;
        b_we    = 1'b0;
        req_ok  = 1'b0;
        req_err = 1'b0;
        if (accept) begin
            unique case (op)
                OP_WRITE_A: a_we = in_rows && in_inner_col;
                OP_WRITE_B: b_we = in_inner_row && in_cols;
                OP_READ_C: begin
                    req_ok  = in_rows && in_cols;
                    req_err = !(in_rows && in_cols);
                end
                default: begin
                end
            endcase
        end
    end

    assign a_raddr = elem_addr(r_row, r_k);
    assign b_raddr = elem_addr(r_k, r_col);
    assign last_k  = ({1'b0, r_k} + (EFF_W+1)'(1)) == {1'b0, sizes.nk};

    mmde_store u_a_store (
        .i_clk   (i_clk),
        .i_we    (a_we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (a_raddr),
        .o_rdata (a_rdata)
    );

    mmde_store u_b_store (
        .i_clk   (i_clk),
        .i_we    (b_we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (b_raddr),
        .o_rdata (b_rdata)
    );

    assign mac_ctl.clear = req_ok;
    assign mac_ctl.load  = r_rd_vld;

    mmde_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (mac_ctl),
        .i_a     (a_rdata),
        .i_b     (b_rdata),
        .o_busy  (mac_busy),
        .o_acc   (acc)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_rd_vld <= 1'b0;
            r_valid  <= 1'b0;
        end else begin
            r_valid  <= 1'b0;
            r_rd_vld <= (r_state == ST_ISSUE);
            unique case (r_state)
                ST_IDLE: begin
                    if (req_ok) begin
                        r_row <= EFF_W'(i_row);
                        r_col <= EFF_W'(i_col);
                        r_k   <= '0;
                        if (sizes.nk == '0) begin
                            r_state <= ST_DRAIN;
                        end else begin
                            r_state <= ST_ISSUE;
                        end
                    end else if (req_err) begin
                        r_valid   <= 1'b1;
                        r_product <= '0;
                        r_error   <= 1'b1;
                    end
                end
                ST_ISSUE: begin
                    r_k <= r_k + EFF_W'(1);
                    if (last_k) begin
                        r_state <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    if (!r_rd_vld && !mac_busy) begin
                        r_valid   <= 1'b1;
                        r_product <= acc;
                        r_error   <= 1'b0;
                        r_state   <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign busy      = (r_state != ST_IDLE);
    assign o_valid   = r_valid;
    assign o_product = r_product;
    assign o_error   = r_error;

endmodule
